FILE: hw/rtl/clp_pkg.sv
// Shared types, codes and byte constants for the chat-log record parser.
package clp_pkg;

    localparam int HEADER_SKIP     = 14;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [3:0] {
        PH_REC  = 4'd0,
        PH_HDR  = 4'd1,
        PH_CHAT = 4'd2,
        PH_PFX  = 4'd3,
        PH_SND  = 4'd4,
        PH_GAP  = 4'd5,
        PH_RCP  = 4'd6,
        PH_TMK  = 4'd7,
        PH_TIM  = 4'd8,
        PH_MMK  = 4'd9,
        PH_MSG  = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        KIND_SND_BYTE = 3'd0,
        KIND_SND_END  = 3'd1,
        KIND_RCP_BYTE = 3'd2,
        KIND_RCP_END  = 3'd3,
        KIND_TIME     = 3'd4,
        KIND_MSG_BYTE = 3'd5,
        KIND_MSG_END  = 3'd6,
        KIND_MISSING  = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        SEC_CHAT      = 3'd0,
        SEC_PREFIX    = 3'd1,
        SEC_SEP       = 3'd2,
        SEC_LIST_END  = 3'd3,
        SEC_TIME_MARK = 3'd4,
        SEC_MSG_MARK  = 3'd5
    } section_t;

    localparam logic [7:0] B_REC0     = 8'h6C;
    localparam logic [7:0] B_REC1     = 8'h33;
    localparam logic [7:0] B_CHAT0    = 8'hE0;
    localparam logic [7:0] B_MARK1    = 8'h03;
    localparam logic [7:0] B_PREFIX   = 8'h23;
    localparam logic [7:0] B_SEP      = 8'h2F;
    localparam logic [7:0] B_LIST_END = 8'h3B;
    localparam logic [7:0] B_TIME0    = 8'hE5;
    localparam logic [7:0] B_MSG0     = 8'hFC;

    localparam logic [1:0] MATCH_DONE = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [2:0]  section;
        logic        last;
    } result_t;

    // Up to two results caused by one input byte.
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } bundle_t;

    function automatic logic [7:0] rec_marker(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = B_REC0;
            2'd1:    r = B_REC1;
            2'd2:    r = B_REC1;
            default: r = B_REC0;
        endcase
        return r;
    endfunction

    // Two-byte overlapping marker search; returns MATCH_DONE on a hit.
    function automatic logic [1:0] match2(input logic [1:0] prog, input logic [7:0] b,
                                          input logic [7:0] first, input logic [7:0] second);
        logic [1:0] r;
        if (prog == 2'd1 && b == second)
            r = MATCH_DONE;
        else if (b == first)
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

endpackage

FILE: hw/rtl/clp_if.sv
// Byte input channel and result output channel interfaces.
interface clp_byte_if;
    import clp_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface clp_result_if;
    import clp_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [2:0]  missing_section;
    logic        last_of_run;

    modport source (output valid, output kind, output value, output missing_section,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input value, input missing_section,
                    input last_of_run, output ready);
endinterface

FILE: hw/rtl/chat_log_record_parser_top.sv
// Top level of the chat-log record parser: front end, result queue, back end.
//
//   channel     dir  beat contents                                  handshake
//   log_bytes   in   data_byte[7:0], stream_end                     valid/ready
//   results     out  kind[2:0], value[31:0], missing_section[2:0],  valid/ready
//                    last_of_run
//
// One byte is accepted per cycle while the result queue has room; the phase
// machine in the front end updates in that same cycle, so bytes may arrive back to back.
// Each byte yields zero, one or two results. The back end sends one result beat
// per cycle while the consumer is ready, so a byte that yields two (only on a
// stream-end beat) needs two beats; the queue absorbs that burst.
// The log_bytes ready drops only while the result queue is full, i.e. when the
// results consumer has stalled long enough to fill it.
// Reset (rst_n low, asynchronous) puts the parser back to searching for a record
// marker and empties the queue and output register; no clearing pass is needed.
module chat_log_record_parser_top #(
    parameter int QUEUE_DEPTH = clp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    clp_byte_if.sink      log_bytes,
    clp_result_if.source  results
);
    import clp_pkg::*;

    bundle_t                 push_bundle;
    logic [$bits(bundle_t)-1:0] pop_bits;
    bundle_t                 pop_bundle;
    logic                    fifo_push;
    logic                    fifo_pop;
    logic                    fifo_full;
    logic                    fifo_empty;

    assign pop_bundle = bundle_t'(pop_bits);

    // Classify bytes and build the results each one causes.
    clp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .log_bytes (log_bytes),
        .full      (fifo_full),
        .push      (fifo_push),
        .bundle    (push_bundle)
    );

    // Hold bundles so each side can stall on its own.
    clp_queue #(
        .WIDTH ($bits(bundle_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (push_bundle),
        .pop       (fifo_pop),
        .pop_data  (pop_bits),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    // Serialize bundles into result beats.
    clp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (fifo_empty),
        .pop_data (pop_bundle),
        .pop      (fifo_pop),
        .results  (results)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_full)
        else $error("result queue overflow");

    // A missing-section flag or a message end always closes the run of its byte.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.kind == KIND_MISSING || results.kind == KIND_MSG_END))
        |-> results.last_of_run)
        else $error("end result not marked last of run");

    // Section code is zero unless a section is flagged missing.
    a_section_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.kind != KIND_MISSING) |-> results.missing_section == 3'd0)
        else $error("section code on a non-missing result");

    // A beat that is not last of run is followed at once by its partner.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && !results.last_of_run) |=>
        (results.valid && results.last_of_run))
        else $error("second result of a byte did not follow");

endmodule

FILE: hw/rtl/clp_front.sv
// Front end: accepts log bytes, runs the record phase machine, builds result bundles.
module clp_front (
    input  logic              clk,
    input  logic              rst_n,
    clp_byte_if.sink          log_bytes,
    input  logic              full,
    output logic              push,
    output clp_pkg::bundle_t  bundle
);
    import clp_pkg::*;

    localparam phase_t     HDR_TARGET = (HEADER_SKIP == 0) ? PH_CHAT : PH_HDR;
    localparam logic [3:0] SKIP_LAST  = 4'(HEADER_SKIP);

    phase_t      phase_reg, phase_next;
    logic [1:0]  match_reg, match_next;
    logic [3:0]  skip_reg, skip_next;
    logic [31:0] time_reg, time_next;
    logic [2:0]  tidx_reg, tidx_next;
    logic        cut_reg, cut_next;

    logic        accept;
    logic [7:0]  b;
    logic [1:0]  m;
    logic [3:0]  skip_inc;
    logic [4:0]  shamt;
    logic [31:0] tval;
    result_t     p_res, e_res;
    logic        p_valid, e_valid;

    assign log_bytes.ready = !full;
    assign accept          = log_bytes.valid && !full;
    assign b               = log_bytes.data_byte;
    assign skip_inc        = skip_reg + 4'd1;
    assign shamt           = 5'(tidx_reg[1:0]) * 5'd7;

    always_comb
    begin
        phase_next = phase_reg;
        match_next = match_reg;
        skip_next  = skip_reg;
        time_next  = time_reg;
        tidx_next  = tidx_reg;
        cut_next   = cut_reg;
        p_valid    = 1'b0;
        p_res      = '0;
        e_valid    = 1'b0;
        e_res      = '0;
        m          = 2'd0;
        tval       = time_reg | {b[3:0], 28'd0};

        unique case (phase_reg)
            PH_HDR:
            begin
                skip_next = skip_inc;
                if (skip_inc >= SKIP_LAST)
                begin
                    phase_next = PH_CHAT;
                    match_next = 2'd0;
                    skip_next  = 4'd0;
                    cut_next   = 1'b0;
                end
            end
            PH_CHAT:
            begin
                m = match2(match_reg, b, B_CHAT0, B_MARK1);
                match_next = (m == MATCH_DONE) ? 2'd0 : m;
                if (m == MATCH_DONE)
                begin
                    phase_next = PH_PFX;
                    skip_next  = 4'd0;
                    cut_next   = 1'b0;
                end
            end
            PH_PFX:
            begin
                if (b == B_PREFIX)
                begin
                    phase_next = PH_SND;
                    match_next = 2'd0;
                    skip_next  = 4'd0;
                    cut_next   = 1'b0;
                end
            end
            PH_SND:
            begin
                if (b == B_SEP)
                begin
                    p_valid      = 1'b1;
                    p_res.kind   = KIND_SND_END;
                    phase_next   = PH_GAP;
                    match_next   = 2'd0;
                    skip_next    = 4'd0;
                    cut_next     = 1'b0;
                end
                else if (b == 8'd0)
                    cut_next = 1'b1;
                else if (!cut_reg)
                begin
                    p_valid     = 1'b1;
                    p_res.kind  = KIND_SND_BYTE;
                    p_res.value = {24'd0, b};
                end
            end
            PH_GAP:
            begin
                phase_next = PH_RCP;
                match_next = 2'd0;
                skip_next  = 4'd0;
                cut_next   = 1'b0;
            end
            PH_RCP:
            begin
                if (b == B_LIST_END)
                begin
                    p_valid    = 1'b1;
                    p_res.kind = KIND_RCP_END;
                    phase_next = PH_TMK;
                    match_next = 2'd0;
                    skip_next  = 4'd0;
                    cut_next   = 1'b0;
                end
                else if (b == 8'd0)
                    cut_next = 1'b1;
                else if (!cut_reg)
                begin
                    p_valid     = 1'b1;
                    p_res.kind  = KIND_RCP_BYTE;
                    p_res.value = {24'd0, b};
                end
            end
            PH_TMK:
            begin
                m = match2(match_reg, b, B_TIME0, B_MARK1);
                match_next = (m == MATCH_DONE) ? 2'd0 : m;
                if (m == MATCH_DONE)
                begin
                    phase_next = PH_TIM;
                    skip_next  = 4'd0;
                    cut_next   = 1'b0;
                    time_next  = 32'd0;
                    tidx_next  = 3'd0;
                end
            end
            PH_TIM:
            begin
                if (tidx_reg < 3'd4)
                begin
                    time_next = time_reg | ({25'd0, b[6:0]} << shamt);
                    tidx_next = tidx_reg + 3'd1;
                end
                else if (tidx_reg == 3'd4)
                begin
                    time_next   = tval;
                    p_valid     = 1'b1;
                    p_res.kind  = KIND_TIME;
                    p_res.value = tval;
                    tidx_next   = 3'd5;
                end
                else
                begin
                    // Drop the sixth time byte.
                    tidx_next  = 3'd0;
                    phase_next = PH_MMK;
                    match_next = 2'd0;
                    skip_next  = 4'd0;
                    cut_next   = 1'b0;
                end
            end
            PH_MMK:
            begin
                m = match2(match_reg, b, B_MSG0, B_MARK1);
                match_next = (m == MATCH_DONE) ? 2'd0 : m;
                if (m == MATCH_DONE)
                begin
                    phase_next = PH_MSG;
                    skip_next  = 4'd0;
                    cut_next   = 1'b0;
                end
            end
            PH_MSG:
            begin
                p_valid = 1'b1;
                if (b == 8'd0)
                begin
                    p_res.kind = KIND_MSG_END;
                    phase_next = PH_REC;
                    match_next = 2'd0;
                    skip_next  = 4'd0;
                    cut_next   = 1'b0;
                end
                else
                begin
                    p_res.kind  = KIND_MSG_BYTE;
                    p_res.value = {24'd0, b};
                end
            end
            default:
            begin
                phase_next = PH_REC;
                if (b == rec_marker(match_reg))
                begin
                    if (match_reg == 2'd3)
                    begin
                        phase_next = HDR_TARGET;
                        match_next = 2'd0;
                        skip_next  = 4'd0;
                        cut_next   = 1'b0;
                    end
                    else
                        match_next = match_reg + 2'd1;
                end
                else
                    match_next = (b == B_REC0) ? 2'd1 : 2'd0;
            end
        endcase

        if (log_bytes.stream_end)
        begin
            e_valid    = 1'b1;
            e_res.kind = KIND_MISSING;
            unique case (phase_next)
                PH_HDR, PH_CHAT: e_res.section = SEC_CHAT;
                PH_PFX:          e_res.section = SEC_PREFIX;
                PH_SND:          e_res.section = SEC_SEP;
                PH_GAP, PH_RCP:  e_res.section = SEC_LIST_END;
                PH_TMK:          e_res.section = SEC_TIME_MARK;
                PH_TIM, PH_MMK:  e_res.section = SEC_MSG_MARK;
                PH_MSG:          e_res.kind    = KIND_MSG_END;
                default:         e_valid       = 1'b0;
            endcase
            phase_next = PH_REC;
            match_next = 2'd0;
            skip_next  = 4'd0;
            time_next  = 32'd0;
            tidx_next  = 3'd0;
            cut_next   = 1'b0;
        end

        bundle = '0;
        if (p_valid && e_valid)
        begin
            bundle.first       = p_res;
            bundle.second      = e_res;
            bundle.second.last = 1'b1;
            bundle.two         = 1'b1;
        end
        else
        begin
            bundle.first      = p_valid ? p_res : e_res;
            bundle.first.last = 1'b1;
        end
        push = accept && (p_valid || e_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_REC;
            match_reg <= 2'd0;
            skip_reg  <= 4'd0;
            time_reg  <= 32'd0;
            tidx_reg  <= 3'd0;
            cut_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            skip_reg  <= skip_next;
            time_reg  <= time_next;
            tidx_reg  <= tidx_next;
            cut_reg   <= cut_next;
        end
    end

endmodule

FILE: hw/rtl/clp_queue.sv
// Small register queue of result bundles between front and back ends.
module clp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    import clp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/clp_back.sv
// Back end: unpacks result bundles into single result beats behind an output register.
module clp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  clp_pkg::bundle_t  pop_data,
    output logic              pop,
    clp_result_if.source      results
);
    import clp_pkg::*;

    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t pend_reg, pend_next;
    logic    pend_valid_reg, pend_valid_next;
    logic    advance;

    assign advance = !out_valid_reg || results.ready;
    assign pop     = advance && !pend_valid_reg && !empty;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (advance)
        begin
            if (pend_valid_reg)
            begin
                // Send the second result of the held bundle.
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (!empty)
            begin
                out_next        = pop_data.first;
                out_valid_next  = 1'b1;
                pend_next       = pop_data.second;
                pend_valid_next = pop_data.two;
            end
            else
                out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.kind            = out_reg.kind;
    assign results.value           = out_reg.value;
    assign results.missing_section = out_reg.section;
    assign results.last_of_run     = out_reg.last;

endmodule

FILE: sim/chat_log_record_parser_checker.sv
// Result predictor and comparator for the chat-log record parser.
module chat_log_record_parser_checker (
    input  logic   clk,
    input  logic   rst_n,
    clp_byte_if    log_bytes,
    clp_result_if  results,
    output int     errors,
    output int     pending
);
    import clp_pkg::*;

    // missing_section reads zero for every kind but a missing section
    localparam section_t NO_SECTION = SEC_CHAT;
    localparam logic [31:0] REC_MARK = {B_REC0, B_REC1, B_REC1, B_REC0};

    phase_t      ph;
    logic [1:0]  prog;
    logic [3:0]  skips;
    logic [31:0] stamp;
    logic [2:0]  stamp_idx;
    logic        cut;

    result_t run_q[$];
    result_t expected_q[$];

    function automatic void enter_phase(phase_t p);
        ph    = p;
        prog  = 2'd0;
        skips = 4'd0;
        cut   = 1'b0;
    endfunction

    function automatic void clear_state();
        enter_phase(PH_REC);
        stamp     = 32'd0;
        stamp_idx = 3'd0;
    endfunction

    function automatic void emit(kind_t k, logic [31:0] v, section_t s);
        result_t r;
        r.kind    = k;
        r.value   = v;
        r.section = s;
        r.last    = 1'b0;
        run_q.push_back(r);
    endfunction

    // Overlapping two-byte search: a lead byte always restarts the match.
    function automatic logic [1:0] pair_search(logic [1:0] so_far, logic [7:0] b,
                                               logic [7:0] lead, logic [7:0] tail);
        logic [1:0] r;
        if (so_far == 2'd1 && b == tail)
            r = MATCH_DONE;
        else if (b == lead)
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic fin);
        logic [1:0] m;
        run_q.delete();
        case (ph)
            PH_HDR:
            begin
                skips = skips + 4'd1;
                if (skips >= HEADER_SKIP)
                    enter_phase(PH_CHAT);
            end
            PH_CHAT:
            begin
                m = pair_search(prog, b, B_CHAT0, B_MARK1);
                if (m == MATCH_DONE)
                    enter_phase(PH_PFX);
                else
                    prog = m;
            end
            PH_PFX:
            begin
                if (b == B_PREFIX)
                    enter_phase(PH_SND);
            end
            PH_SND:
            begin
                if (b == B_SEP)
                begin
                    emit(KIND_SND_END, 32'd0, NO_SECTION);
                    enter_phase(PH_GAP);
                end
                else if (b == 8'd0)
                    cut = 1'b1;
                else if (!cut)
                    emit(KIND_SND_BYTE, {24'd0, b}, NO_SECTION);
            end
            PH_GAP:
            begin
                enter_phase(PH_RCP);
            end
            PH_RCP:
            begin
                if (b == B_LIST_END)
                begin
                    emit(KIND_RCP_END, 32'd0, NO_SECTION);
                    enter_phase(PH_TMK);
                end
                else if (b == 8'd0)
                    cut = 1'b1;
                else if (!cut)
                    emit(KIND_RCP_BYTE, {24'd0, b}, NO_SECTION);
            end
            PH_TMK:
            begin
                m = pair_search(prog, b, B_TIME0, B_MARK1);
                if (m == MATCH_DONE)
                begin
                    enter_phase(PH_TIM);
                    stamp     = 32'd0;
                    stamp_idx = 3'd0;
                end
                else
                    prog = m;
            end
            PH_TIM:
            begin
                if (stamp_idx < 3'd4)
                begin
                    stamp     = stamp | (32'(b[6:0]) << (7 * stamp_idx));
                    stamp_idx = stamp_idx + 3'd1;
                end
                else if (stamp_idx == 3'd4)
                begin
                    stamp     = stamp | {b[3:0], 28'd0};
                    emit(KIND_TIME, stamp, NO_SECTION);
                    stamp_idx = 3'd5;
                end
                else
                begin
                    stamp_idx = 3'd0;
                    enter_phase(PH_MMK);
                end
            end
            PH_MMK:
            begin
                m = pair_search(prog, b, B_MSG0, B_MARK1);
                if (m == MATCH_DONE)
                    enter_phase(PH_MSG);
                else
                    prog = m;
            end
            PH_MSG:
            begin
                if (b == 8'd0)
                begin
                    emit(KIND_MSG_END, 32'd0, NO_SECTION);
                    enter_phase(PH_REC);
                end
                else
                    emit(KIND_MSG_BYTE, {24'd0, b}, NO_SECTION);
            end
            default:
            begin
                ph = PH_REC;
                if (b == REC_MARK[8 * (3 - prog) +: 8])
                begin
                    if (prog == 2'd3)
                        enter_phase((HEADER_SKIP == 0) ? PH_CHAT : PH_HDR);
                    else
                        prog = prog + 2'd1;
                end
                else
                    prog = (b == B_REC0) ? 2'd1 : 2'd0;
            end
        endcase

        // Stream end: flag the section still being sought, close an open message.
        if (fin)
        begin
            case (ph)
                PH_HDR, PH_CHAT: emit(KIND_MISSING, 32'd0, SEC_CHAT);
                PH_PFX:          emit(KIND_MISSING, 32'd0, SEC_PREFIX);
                PH_SND:          emit(KIND_MISSING, 32'd0, SEC_SEP);
                PH_GAP, PH_RCP:  emit(KIND_MISSING, 32'd0, SEC_LIST_END);
                PH_TMK:          emit(KIND_MISSING, 32'd0, SEC_TIME_MARK);
                PH_TIM, PH_MMK:  emit(KIND_MISSING, 32'd0, SEC_MSG_MARK);
                PH_MSG:          emit(KIND_MSG_END, 32'd0, NO_SECTION);
                default:         ;
            endcase
            clear_state();
        end

        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i])
            expected_q.push_back(run_q[i]);
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result();
        result_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual kind %0d value %0h %s",
                     $time, results.kind, results.value,
                     $sformatf("section %0d last %0b", results.missing_section,
                               results.last_of_run));
            errors++;
        end
        else
        begin
            want = expected_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(results.kind));
            compare_field("value", want.value, results.value);
            compare_field("missing_section", 32'(want.section), 32'(results.missing_section));
            compare_field("last_of_run", 32'(want.last), 32'(results.last_of_run));
        end
    endfunction

    // Predict from the input beat before checking the output beat of the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            if (log_bytes.valid && log_bytes.ready)
                predict_byte(log_bytes.data_byte, log_bytes.stream_end);
            if (results.valid && results.ready)
                check_result();
        end
        pending = expected_q.size();
    end

endmodule

FILE: sim/chat_log_record_parser_top_test.sv
// Testbench top for the chat-log record parser: clock, reset, stimulus, verdict.
module chat_log_record_parser_top_test;
    import clp_pkg::*;

    localparam int RANDOM_BYTES = 1250;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PAUSE_RECORD = 12;

    // Stall styles of the result consumer.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_LONG
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycle_count = 0;
    int   burst_left = 0;
    int   counted_bytes = 0;

    clp_byte_if   log_bytes ();
    clp_result_if results ();

    chat_log_record_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .log_bytes (log_bytes),
        .results   (results)
    );

    chat_log_record_parser_checker parse_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .log_bytes (log_bytes),
        .results   (results),
        .errors    (errors),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    // Guard against a hung handshake: end the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Send one beat. Entered and left at a falling edge. The sender works in
    // bursts; between bursts it sometimes idles for a random gap, and now and
    // then a very long burst gives a stretch without any gap.
    task automatic put_byte(input logic [7:0] b, input logic fin, input logic counted);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                log_bytes.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        log_bytes.valid      <= 1'b1;
        log_bytes.data_byte  <= b;
        log_bytes.stream_end <= fin;
        // Hold the beat until the parser takes it.
        @(posedge clk);
        while (!log_bytes.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (counted)
            counted_bytes++;
    endtask

    // Drop valid and hold off until every predicted result has come out.
    task automatic drain_pause();
        log_bytes.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    // Search filler that often hits the first or second byte of a two-byte
    // marker, so restarts of the overlapping search get exercised.
    function automatic logic [7:0] near_miss(logic [7:0] lead, logic [7:0] tail);
        logic [7:0] v;
        case ($urandom_range(0, 5))
            0, 1:    v = lead;
            2:       v = tail;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // Sender or recipient content: never the terminator, sometimes a zero that
    // cuts the rest of the field.
    function automatic logic [7:0] field_byte(logic [7:0] stop);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            v = 8'd0;
        else if (v == stop)
            v = ~stop;
        return v;
    endfunction

    // Build one record with random content and send it. Most records are well
    // formed; some are cut by a stream end placed in a random section, some end
    // the stream on their last byte, and a few leave the message unterminated.
    task automatic send_record();
        logic [7:0] rec[$];
        int         starts[12];
        int         i;
        int         n;
        int         s;
        int         lo;
        int         hi;
        int         stop_at;
        logic       open_msg;

        // Leading noise, ignored by the marker search.
        starts[0] = 0;
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++)
            rec.push_back(8'($urandom_range(0, 255)));

        // Record marker, sometimes after a broken attempt at it.
        starts[1] = rec.size();
        case ($urandom_range(0, 3))
            1:
            begin
                rec.push_back(B_REC0);
            end
            2:
            begin
                rec.push_back(B_REC0);
                rec.push_back(B_REC1);
            end
            3:
            begin
                rec.push_back(B_REC0);
                rec.push_back(B_REC1);
                rec.push_back(B_REC1);
                rec.push_back(B_REC1);
            end
            default: ;
        endcase
        rec.push_back(B_REC0);
        rec.push_back(B_REC1);
        rec.push_back(B_REC1);
        rec.push_back(B_REC0);

        // Header bytes are skipped whatever they hold.
        starts[2] = rec.size();
        for (i = 0; i < HEADER_SKIP; i++)
            rec.push_back(8'($urandom_range(0, 255)));

        starts[3] = rec.size();
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
            rec.push_back(near_miss(B_CHAT0, B_MARK1));
        rec.push_back(B_CHAT0);
        rec.push_back(B_MARK1);

        starts[4] = rec.size();
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++)
            rec.push_back(8'($urandom_range(0, 255)));
        rec.push_back(B_PREFIX);

        starts[5] = rec.size();
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++)
            rec.push_back(field_byte(B_SEP));
        rec.push_back(B_SEP);

        // The byte after the separator is skipped.
        starts[6] = rec.size();
        rec.push_back(8'($urandom_range(0, 255)));

        starts[7] = rec.size();
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++)
            rec.push_back(field_byte(B_LIST_END));
        rec.push_back(B_LIST_END);

        starts[8] = rec.size();
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
            rec.push_back(near_miss(B_TIME0, B_MARK1));
        rec.push_back(B_TIME0);
        rec.push_back(B_MARK1);

        // Five timestamp bytes plus the skipped sixth, full random range.
        starts[9] = rec.size();
        for (i = 0; i < 6; i++)
            rec.push_back(8'($urandom_range(0, 255)));

        starts[10] = rec.size();
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
            rec.push_back(near_miss(B_MSG0, B_MARK1));
        rec.push_back(B_MSG0);
        rec.push_back(B_MARK1);

        starts[11] = rec.size();
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++)
            rec.push_back(8'($urandom_range(1, 255)));
        open_msg = ($urandom_range(0, 5) == 0);
        if (!open_msg)
            rec.push_back(8'd0);

        // Pick where, if anywhere, the stream ends.
        stop_at = -1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                s  = $urandom_range(1, 11);
                lo = starts[s];
                hi = ((s == 11) ? rec.size() : starts[s + 1]) - 1;
                if (hi >= lo)
                    stop_at = $urandom_range(lo, hi);
            end
            4, 5:
            begin
                stop_at = rec.size() - 1;
            end
            default: ;
        endcase

        n = (stop_at >= 0) ? stop_at + 1 : rec.size();
        for (i = 0; i < n; i++)
            put_byte(rec[i], i == stop_at, i >= starts[1]);
    endtask

    // Result consumer: ready changes at the falling edge, cycling through
    // stretches of always-ready, coin-flip, periodic and long stalls. Long
    // stalls fill the result queue and push back on the byte channel.
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       i;
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(10, 80);
            for (i = 0; i < span; i++)
            begin
                case (mode)
                    RX_OPEN:     results.ready <= 1'b1;
                    RX_COIN:     results.ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: results.ready <= ((i % 5) != 0);
                    default:     results.ready <= ((i % 40) >= 25);
                endcase
                @(negedge clk);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [7:0] opening[$];
        logic [7:0] body[$];
        int         i;
        int         records;

        log_bytes.valid      = 1'b0;
        log_bytes.data_byte  = 8'd0;
        log_bytes.stream_end = 1'b0;
        rst_n                = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed record: record marker after an overlapping false start,
        // header of extreme bytes, doubled lead bytes on every two-byte marker,
        // a sender cut by an embedded zero, a recipient list cut the same way,
        // an all-ones timestamp, then stream end inside the message so it is
        // closed without its zero. A lone end beat while idle follows.
        opening = '{B_REC0, B_REC0, B_REC1, B_REC1, B_REC0};
        body = '{B_CHAT0, B_CHAT0, B_MARK1, B_PREFIX,
                 8'h01, 8'hFF, 8'h00, 8'h41, B_SEP, B_SEP,
                 8'h80, 8'h00, 8'h7F, B_LIST_END,
                 B_TIME0, B_TIME0, B_MARK1,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 B_MSG0, B_MSG0, B_MARK1, 8'hFF, 8'h01};
        foreach (opening[i])
            put_byte(opening[i], 1'b0, 1'b1);
        for (i = 0; i < HEADER_SKIP; i++)
            put_byte(i[0] ? 8'hFF : 8'h00, 1'b0, 1'b1);
        foreach (body[i])
            put_byte(body[i], i == body.size() - 1, 1'b1);
        put_byte(B_REC0, 1'b1, 1'b1);

        // Random records until enough parsed bytes have gone in.
        counted_bytes = 0;
        records = 0;
        while (counted_bytes < RANDOM_BYTES)
        begin
            // Now and then end the stream on a stray byte between records.
            if ($urandom_range(0, 11) == 0)
                put_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            send_record();
            records++;
            if (records == PAUSE_RECORD)
                drain_pause();
        end

        // Drain: wait for every predicted result, then a short tail.
        log_bytes.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/clp_pkg.sv
hw/rtl/clp_if.sv
hw/rtl/clp_front.sv
hw/rtl/clp_queue.sv
hw/rtl/clp_back.sv
hw/rtl/chat_log_record_parser_top.sv
sim/chat_log_record_parser_checker.sv
sim/chat_log_record_parser_top_test.sv
